// ----- rtl/urq_pkg.sv -----
package urq_pkg;

    localparam int QUEUE_DEPTH    = 64;
    localparam int NUM_CTRL_CHARS = 4;

    localparam int BYTE_W     = 8;
    localparam int MARK_W     = 7;
    localparam int LEVEL_W    = 7;
    localparam int CTRL_IDX_W = 2;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > MARK_W) ? CNT_W : MARK_W;

    localparam logic [MARK_W-1:0] HIGH_MARK_RESET = 7'd60;
    localparam logic [MARK_W-1:0] LOW_MARK_RESET  = 7'd16;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 3'd1;
    localparam int                   REG_CTRL_BASE = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 2'd0,
        CMD_READ     = 2'd1,
        CMD_TX_WRITE = 2'd2,
        CMD_TX_EMPTY = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [MARK_W-1:0]                      high_mark;
        logic [MARK_W-1:0]                      low_mark;
        logic [NUM_CTRL_CHARS-1:0][BYTE_W-1:0]  ctrl_char;
    } t_cfg;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [BYTE_W-1:0] head;
        logic [CNT_W-1:0]  n_count;
        logic              n_rts;
    } t_q_stat;

endpackage

// ----- rtl/uart_rx_queue_rts_flow_control_unit.sv -----
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_command, i_byte_in
// out     | output    | o_out_valid / i_out_ready   | o_read_byte ... o_queue_level
// cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one beat per cycle sustained while i_out_ready holds; a result passes through
// the input register and then the result register.
// queue head is prefetched into a register so a host read takes it straight from there.
// a stalled result holds the pipeline; the input register refills as soon as it moves.
// synchronous reset clears pointers, fill count, flags and config; no clearing pass.
module uart_rx_queue_rts_flow_control_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [urq_pkg::CMD_W-1:0]         i_command,
    input  logic [urq_pkg::BYTE_W-1:0]        i_byte_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [urq_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                              o_read_valid,
    output logic                              o_ctrl_hit,
    output logic [urq_pkg::CTRL_IDX_W-1:0]    o_ctrl_index,
    output logic                              o_rx_dropped,
    output logic                              o_rts_level,
    output logic                              o_tx_busy,
    output logic [urq_pkg::BYTE_W-1:0]        o_tx_out,
    output logic                              o_tx_accepted,
    output logic                              o_rx_available,
    output logic [urq_pkg::LEVEL_W-1:0]       o_queue_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [urq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [urq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import urq_pkg::*;

    t_cfg    cfg;
    t_q_stat stat;

    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_byte;

    logic              advance, proc;
    logic              hit;
    logic [CTRL_IDX_W-1:0] hit_idx;
    logic              push, pop;
    logic              r_tx_pending, n_tx_pending;
    logic              tx_acc;
    logic [CMP_W-1:0]  level_ext;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_read_byte;
    logic                  r_read_valid;
    logic                  r_ctrl_hit;
    logic [CTRL_IDX_W-1:0] r_ctrl_index;
    logic                  r_rx_dropped;
    logic                  r_rts_level;
    logic                  r_tx_busy;
    logic [BYTE_W-1:0]     r_tx_out;
    logic                  r_tx_accepted;
    logic                  r_rx_available;
    logic [LEVEL_W-1:0]    r_queue_level;

    urq_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    assign advance    = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_byte <= i_byte_in;
        end
    end

    // lowest matching index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_CTRL_CHARS - 1; i >= 0; i--) begin
            if ((cfg.ctrl_char[i] != '0) && (cfg.ctrl_char[i] == r_byte)) begin
                hit     = 1'b1;
                hit_idx = CTRL_IDX_W'(i);
            end
        end
    end

    assign push = proc && (r_cmd == CMD_RX_BYTE) && !hit && !stat.full;
    assign pop  = proc && (r_cmd == CMD_READ) && !stat.empty;

    urq_rx_queue u_rx_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (r_byte),
        .i_pop       (pop),
        .i_high_mark (cfg.high_mark),
        .i_low_mark  (cfg.low_mark),
        .o_stat      (stat)
    );

    always_comb begin
        n_tx_pending = r_tx_pending;
        tx_acc       = 1'b0;
        case (r_cmd)
            CMD_TX_WRITE: begin
                if (!r_tx_pending) begin
                    n_tx_pending = 1'b1;
                    tx_acc       = 1'b1;
                end
            end
            CMD_TX_EMPTY: begin
                n_tx_pending = 1'b0;
            end
            default: begin
                n_tx_pending = r_tx_pending;
            end
        endcase
    end

    assign level_ext = CMP_W'(stat.n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (proc) begin
                r_tx_pending <= n_tx_pending;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_read_byte    <= pop ? stat.head : '0;
            r_read_valid   <= pop;
            r_ctrl_hit     <= (r_cmd == CMD_RX_BYTE) && hit;
            r_ctrl_index   <= (r_cmd == CMD_RX_BYTE) ? hit_idx : '0;
            r_rx_dropped   <= (r_cmd == CMD_RX_BYTE) && !hit && stat.full;
            r_rts_level    <= stat.n_rts;
            r_tx_busy      <= n_tx_pending;
            r_tx_out       <= tx_acc ? r_byte : '0;
            r_tx_accepted  <= tx_acc;
            r_rx_available <= (stat.n_count != '0);
            r_queue_level  <= level_ext[LEVEL_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_byte    = r_read_byte;
    assign o_read_valid   = r_read_valid;
    assign o_ctrl_hit     = r_ctrl_hit;
    assign o_ctrl_index   = r_ctrl_index;
    assign o_rx_dropped   = r_rx_dropped;
    assign o_rts_level    = r_rts_level;
    assign o_tx_busy      = r_tx_busy;
    assign o_tx_out       = r_tx_out;
    assign o_tx_accepted  = r_tx_accepted;
    assign o_rx_available = r_rx_available;
    assign o_queue_level  = r_queue_level;

endmodule

// ----- rtl/urq_cfg_regs.sv -----
module urq_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [urq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [urq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output urq_pkg::t_cfg                   o_cfg
);
    import urq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_mark <= HIGH_MARK_RESET;
            r_cfg.low_mark  <= LOW_MARK_RESET;
            r_cfg.ctrl_char <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HIGH_MARK) begin
                r_cfg.high_mark <= i_cfg_data[MARK_W-1:0];
            end
            if (i_cfg_index == REG_LOW_MARK) begin
                r_cfg.low_mark <= i_cfg_data[MARK_W-1:0];
            end
            for (int i = 0; i < NUM_CTRL_CHARS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(REG_CTRL_BASE + i)) begin
                    r_cfg.ctrl_char[i] <= i_cfg_data[BYTE_W-1:0];
                end
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/urq_rx_queue.sv -----
module urq_rx_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [urq_pkg::BYTE_W-1:0]   i_push_data,
    input  logic                         i_pop,
    input  logic [urq_pkg::MARK_W-1:0]   i_high_mark,
    input  logic [urq_pkg::MARK_W-1:0]   i_low_mark,
    output urq_pkg::t_q_stat             o_stat
);
    import urq_pkg::*;

    logic [BYTE_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_throttled, n_throttled;
    logic [BYTE_W-1:0] r_head;
    logic              empty, full;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_throttled = r_throttled;
        if (i_push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
            n_count  = r_count + 1'b1;
            if (CMP_W'(n_count) > CMP_W'(i_high_mark)) begin
                n_throttled = 1'b1;
            end
        end else if (i_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
            n_count  = r_count - 1'b1;
            if (r_throttled && (CMP_W'(n_count) < CMP_W'(i_low_mark))) begin
                n_throttled = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_throttled <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_throttled <= n_throttled;
        end
    end

    // head prefetch, bypass when writing into an empty queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_push_data;
        end
        if (i_push && empty) begin
            r_head <= i_push_data;
        end else begin
            r_head <= mem[n_rd_ptr];
        end
    end

    assign o_stat.empty   = empty;
    assign o_stat.full    = full;
    assign o_stat.head    = r_head;
    assign o_stat.n_count = n_count;
    assign o_stat.n_rts   = !n_throttled;

endmodule
